>>> hw/rtl/tksd_pkg.sv
// Package for the terminal key sequence decoder: key codes, modes, sequence table.
`default_nettype none

package tksd_pkg;

  localparam int SeqEntries = 25;
  localparam int SeqIdxW    = $clog2(SeqEntries);
  localparam int PendDepth  = 3;

  localparam logic [7:0] CharHelp    = 8'h3f;  // '?'
  localparam logic [7:0] CharPrintLo = 8'h20;
  localparam logic [7:0] CharPrintHi = 8'h7e;

  typedef enum logic [1:0] {
    MODE_STRING   = 2'd0,
    MODE_PASSWORD = 2'd1,
    MODE_MULTI    = 2'd2,
    MODE_CMD      = 2'd3
  } mode_e;

  typedef enum logic [4:0] {
    KC_PRINT       = 5'd0,
    KC_PARTIAL     = 5'd1,
    KC_IGNORE      = 5'd2,
    KC_ARROW_LEFT  = 5'd3,
    KC_ARROW_RIGHT = 5'd4,
    KC_ARROW_UP    = 5'd5,
    KC_ARROW_DOWN  = 5'd6,
    KC_PAGE_UP     = 5'd7,
    KC_PAGE_DOWN   = 5'd8,
    KC_DELETE      = 5'd9,
    KC_BACKSPACE   = 5'd10,
    KC_LINE_START  = 5'd11,
    KC_ABORT       = 5'd12,
    KC_LINE_END    = 5'd13,
    KC_TAB         = 5'd14,
    KC_WIPE        = 5'd15,
    KC_REDRAW      = 5'd16,
    KC_RETURN      = 5'd17,
    KC_SWAP        = 5'd18,
    KC_EOF         = 5'd19,
    KC_HELP_REQ    = 5'd20
  } key_e;

  // bytes[0] is the first byte of the sequence
  typedef struct packed {
    logic [2:0]      len;
    logic [3:0][7:0] bytes;
    key_e            key;
  } seq_entry_t;

  // result of matching one byte against the pending sequence
  typedef struct packed {
    key_e       key;
    logic [7:0] char_val;
    logic [1:0] count;   // pending count after this byte
    logic       store;   // keep the byte as a pending byte
  } match_res_t;

  localparam seq_entry_t SeqTable [SeqEntries] = '{
    '{3'd3, {8'h00, 8'h44, 8'h5b, 8'h1b}, KC_ARROW_LEFT},
    '{3'd3, {8'h00, 8'h43, 8'h5b, 8'h1b}, KC_ARROW_RIGHT},
    '{3'd3, {8'h00, 8'h41, 8'h5b, 8'h1b}, KC_ARROW_UP},
    '{3'd3, {8'h00, 8'h42, 8'h5b, 8'h1b}, KC_ARROW_DOWN},
    '{3'd4, {8'h7e, 8'h35, 8'h5b, 8'h1b}, KC_PAGE_UP},
    '{3'd4, {8'h7e, 8'h36, 8'h5b, 8'h1b}, KC_PAGE_DOWN},
    '{3'd4, {8'h7e, 8'h33, 8'h5b, 8'h1b}, KC_DELETE},
    '{3'd1, {8'h00, 8'h00, 8'h00, 8'h7f}, KC_BACKSPACE},
    '{3'd1, {8'h00, 8'h00, 8'h00, 8'h01}, KC_LINE_START},
    '{3'd1, {8'h00, 8'h00, 8'h00, 8'h03}, KC_ABORT},
    '{3'd1, {8'h00, 8'h00, 8'h00, 8'h04}, KC_DELETE},
    '{3'd1, {8'h00, 8'h00, 8'h00, 8'h05}, KC_LINE_END},
    '{3'd1, {8'h00, 8'h00, 8'h00, 8'h08}, KC_BACKSPACE},
    '{3'd1, {8'h00, 8'h00, 8'h00, 8'h09}, KC_TAB},
    '{3'd1, {8'h00, 8'h00, 8'h00, 8'h0b}, KC_WIPE},
    '{3'd1, {8'h00, 8'h00, 8'h00, 8'h0c}, KC_REDRAW},
    '{3'd1, {8'h00, 8'h00, 8'h00, 8'h0d}, KC_RETURN},
    '{3'd1, {8'h00, 8'h00, 8'h00, 8'h14}, KC_SWAP},
    '{3'd1, {8'h00, 8'h00, 8'h00, 8'h1a}, KC_EOF},
    '{3'd2, {8'h00, 8'h00, 8'h1b, 8'h1b}, KC_IGNORE},
    '{3'd3, {8'h00, 8'h48, 8'h5b, 8'h1b}, KC_IGNORE},
    '{3'd3, {8'h00, 8'h46, 8'h5b, 8'h1b}, KC_IGNORE},
    '{3'd2, {8'h00, 8'h00, 8'h4f, 8'h1b}, KC_IGNORE},
    '{3'd3, {8'h00, 8'h31, 8'h5b, 8'h1b}, KC_IGNORE},
    '{3'd3, {8'h00, 8'h32, 8'h5b, 8'h1b}, KC_IGNORE}
  };

endpackage

`default_nettype wire

>>> hw/rtl/tksd_match.sv
// Sequence table match: classifies one byte against the pending bytes.
`default_nettype none

module tksd_match import tksd_pkg::*; (
  input  wire logic [7:0] byte_i,
  input  wire logic [1:0] count_i,
  input  wire logic [7:0] pend0_i,
  input  wire logic [7:0] pend1_i,
  input  wire logic [7:0] pend2_i,
  input  wire mode_e      mode_i,
  output match_res_t      res_o
);

  logic [3:0][7:0]      seq;
  logic [2:0]           m;
  logic [SeqEntries-1:0] hit;
  logic                 found;
  logic [SeqIdxW-1:0]   sel;
  seq_entry_t           ent;

  always_comb begin
    // appended sequence: pending bytes, then the new byte, then zeros
    seq = '0;
    seq[0] = (count_i == 2'd0) ? byte_i : pend0_i;
    if (count_i > 2'd1) begin
      seq[1] = pend1_i;
    end else if (count_i == 2'd1) begin
      seq[1] = byte_i;
    end
    if (count_i == 2'd3) begin
      seq[2] = pend2_i;
    end else if (count_i == 2'd2) begin
      seq[2] = byte_i;
    end
    if (count_i == 2'd3) begin
      seq[3] = byte_i;
    end
    m = {1'b0, count_i} + 3'd1;

    for (int e = 0; e < SeqEntries; e++) begin
      hit[e] = (SeqTable[e].len >= m);
      for (int j = 0; j < 4; j++) begin
        if ((3'(j) < m) && (SeqTable[e].bytes[j] != seq[j])) begin
          hit[e] = 1'b0;
        end
      end
    end

    // first hit in table order wins
    found = 1'b0;
    sel   = '0;
    for (int e = 0; e < SeqEntries; e++) begin
      if (!found && hit[e]) begin
        found = 1'b1;
        sel   = SeqIdxW'(e);
      end
    end
    ent = SeqTable[sel];

    res_o.char_val = 8'h00;
    res_o.count    = 2'd0;
    res_o.store    = 1'b0;
    if (found) begin
      if (ent.len == m) begin
        res_o.key = (mode_i == MODE_MULTI && ent.key == KC_DELETE) ? KC_EOF : ent.key;
      end else begin
        res_o.key   = KC_PARTIAL;
        res_o.count = m[1:0];
        res_o.store = 1'b1;
      end
    end else if (mode_i == MODE_CMD && byte_i == CharHelp) begin
      res_o.key = KC_HELP_REQ;
    end else if (byte_i >= CharPrintLo && byte_i <= CharPrintHi) begin
      res_o.key      = KC_PRINT;
      res_o.char_val = byte_i;
    end else begin
      res_o.key = KC_IGNORE;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/terminal_key_sequence_decoder.sv
// Top level of the terminal key sequence decoder: stream ports, registers, state.
// Decodes raw terminal bytes into key codes, one result per input byte. A byte is
// taken into an input register, matched against the fixed sequence table in
// combinational logic and written to the output register together with the
// updated pending-sequence state, so one byte per clock is sustained while
// m_axis_tready drains the output. The rate is set by the single match stage,
// which reads the pending state that the previous byte left. The input register
// keeps accepting while the output holds a result waiting for tready, and stalls
// only when both registers are full. The user must write edit_mode through cfg_we_i /
// cfg_wdata_i only while the block is idle; the block does not enforce it. No read-back.
`default_nettype none

module terminal_key_sequence_decoder import tksd_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // configuration
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_wdata_i,    // edit_mode
  // input stream
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] byte_in
  // output stream
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0]      m_axis_tdata    // [4:0] key_code, [12:5] char_out, [15:13] zero
);

  mode_e       mode_q;
  logic        in_valid_q;
  logic [7:0]  in_byte_q;
  logic        out_valid_q;
  key_e        out_key_q;
  logic [7:0]  out_char_q;
  logic [1:0]  pend_count_q;
  logic [7:0]  pend_q [PendDepth];
  logic        advance;
  logic        in_xfer;
  match_res_t  res;

  // match stage moves when the output register is free or being drained
  assign advance       = !out_valid_q || m_axis_tready;
  assign s_axis_tready = !in_valid_q || advance;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_STRING;
    end else if (cfg_we_i) begin
      mode_q <= mode_e'(cfg_wdata_i);
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      in_byte_q <= s_axis_tdata;
    end
  end

  tksd_match u_match (
    .byte_i  (in_byte_q),
    .count_i (pend_count_q),
    .pend0_i (pend_q[0]),
    .pend1_i (pend_q[1]),
    .pend2_i (pend_q[2]),
    .mode_i  (mode_q),
    .res_o   (res)
  );

  // output register and pending state update together
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      pend_count_q <= 2'd0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
      if (in_valid_q) begin
        pend_count_q <= res.count;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && in_valid_q) begin
      out_key_q  <= res.key;
      out_char_q <= res.char_val;
    end
  end

  // pending bytes: no reset, only entries below the count are read
  always_ff @(posedge clk_i) begin
    if (advance && in_valid_q && res.store && pend_count_q != 2'd3) begin
      pend_q[pend_count_q] <= in_byte_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'b000, out_char_q, out_key_q};

  // a waiting partial result leaves bytes pending, any other leaves none
  a_partial_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> ((out_key_q == KC_PARTIAL) == (pend_count_q != 2'd0)))
    else $error("pending count disagrees with result key");

  // only printable results carry a character
  a_char_print: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_char_q != 8'h00) |-> (out_key_q == KC_PRINT))
    else $error("character on a non-printable result");

  // input stalls only with both registers full
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (in_valid_q && out_valid_q && !m_axis_tready))
    else $error("input stalled with room in the pipeline");

endmodule

`default_nettype wire
